>>> design/ntfsrl_pkg.sv
// shared types and codes for the ntfs runlist decoder
`timescale 1ns / 1ps

package ntfsrl_pkg;

   localparam int unsigned WordWidth = 64;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_RUN     = 2'd0;
   localparam status_type STATUS_DONE    = 2'd1;
   localparam status_type STATUS_CORRUPT = 2'd2;

   localparam logic [7:0] NIBBLE_MASK = 8'h0F;
   localparam logic [7:0] SIGN_BIT    = 8'h80;

   typedef struct packed {
      logic [WordWidth-1:0] vcn;
      logic [WordWidth-1:0] lcn;
      logic [WordWidth-1:0] length;
      logic                 hole;
      status_type           status;
      logic                 last;
   } result_type;

   // or one byte into a little-endian accumulator, bytes past the eighth are dropped
   function automatic logic [WordWidth-1:0] gather_byte(input logic [WordWidth-1:0] acc,
                                                        input logic [7:0] data,
                                                        input logic [3:0] idx);
      logic [WordWidth-1:0] shifted;
      shifted = {{(WordWidth-8){1'b0}}, data} << {idx[2:0], 3'b000};
      if (idx[3] == 1'b0) begin
         gather_byte = acc | shifted;
      end else begin
         gather_byte = acc;
      end
   endfunction

   // sign extension from the top byte of a field shorter than eight bytes
   function automatic logic [WordWidth-1:0] extend_field(input logic [WordWidth-1:0] acc,
                                                         input logic [3:0] total,
                                                         input logic [7:0] top);
      logic [WordWidth-1:0] fill;
      fill = {WordWidth{1'b1}} << {total[2:0], 3'b000};
      if ((total[3] == 1'b0) && ((top & SIGN_BIT) != 8'h00)) begin
         extend_field = acc | fill;
      end else begin
         extend_field = acc;
      end
   endfunction

endpackage

>>> design/ntfs_runlist_decoder.sv
// ntfs mapping-pairs runlist decoder, top level
`timescale 1ns / 1ps
// usage
//   req channel: one mapping-pairs byte per beat, req_end_of_stream on the last byte
//     of an attribute
//   rsp channel: at most one beat per input byte: a run (virtual start, absolute
//     cluster, length, hole mark), done on a zero header, or corrupt on a zero length
//     nibble or a truncated run; rsp_last marks the final beat of a stream
//   after done or corrupt the rest of the stream is swallowed up to its last byte
// timing
//   one byte per cycle sustained while req_ready is high; the decode is one pass of
//   gather, sign extend and a 64-bit add between the state registers and the result
//   register or the skid register
//   a two-entry output stage (result register plus skid register) lets bytes keep
//   flowing while a result waits; req_ready drops only once the skid register is
//   full, so a stalled receiver holds the input back after one extra result
// reset
//   synchronous reset clears the decode state to expect header with zero cluster and
//   virtual positions and empties the output stage; every end-of-stream byte does
//   the same for the decode state
module ntfs_runlist_decoder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [7:0]                            req_data_byte,
   input  logic                                  req_end_of_stream,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [ntfsrl_pkg::WordWidth-1:0]        rsp_run_vcn,
   output logic signed [ntfsrl_pkg::WordWidth-1:0] rsp_run_lcn,
   output logic signed [ntfsrl_pkg::WordWidth-1:0] rsp_run_length,
   output logic                                  rsp_is_hole,
   output logic [1:0]                            rsp_status,
   output logic                                  rsp_last
);
   import ntfsrl_pkg::*;

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_LENGTH = 2'd1;
   localparam logic [1:0] PH_OFFSET = 2'd2;
   localparam logic [1:0] PH_SKIP   = 2'd3;

   // decode state
   logic [1:0]           phase_ff, phase_in;
   logic [3:0]           len_total_ff, len_total_in;
   logic [3:0]           off_total_ff, off_total_in;
   logic [3:0]           count_ff, count_in;
   logic [WordWidth-1:0] len_acc_ff, len_acc_in;
   logic [WordWidth-1:0] delta_acc_ff, delta_acc_in;
   logic [WordWidth-1:0] prev_cluster_ff, prev_cluster_in;
   logic [WordWidth-1:0] virt_pos_ff, virt_pos_in;

   // output stage
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;

   logic                 req_fire;
   logic                 out_fire;
   logic                 emit;
   result_type           result;
   logic [3:0]           count_next;
   logic [WordWidth-1:0] len_gathered;
   logic [WordWidth-1:0] len_final;
   logic [WordWidth-1:0] delta_gathered;
   logic [WordWidth-1:0] delta_final;
   logic [WordWidth-1:0] cluster_sum;

   assign req_ready = ~skid_valid_ff;
   assign req_fire  = req_valid & req_ready;
   assign out_fire  = out_valid_ff & rsp_ready;

   assign count_next     = count_ff + 4'd1;
   assign len_gathered   = gather_byte(len_acc_ff, req_data_byte, count_ff);
   assign len_final      = extend_field(len_gathered, len_total_ff, req_data_byte);
   assign delta_gathered = gather_byte(delta_acc_ff, req_data_byte, count_ff);
   assign delta_final    = extend_field(delta_gathered, off_total_ff, req_data_byte);
   assign cluster_sum    = prev_cluster_ff + delta_final;

   always_comb begin
      phase_in        = phase_ff;
      len_total_in    = len_total_ff;
      off_total_in    = off_total_ff;
      count_in        = count_ff;
      len_acc_in      = len_acc_ff;
      delta_acc_in    = delta_acc_ff;
      prev_cluster_in = prev_cluster_ff;
      virt_pos_in     = virt_pos_ff;
      emit            = 1'b0;
      result          = '0;

      if (req_fire) begin
         unique case (phase_ff)
            PH_SKIP: begin
               phase_in = PH_SKIP;
            end
            PH_HEADER: begin
               if (req_data_byte == 8'h00) begin
                  emit          = 1'b1;
                  result.status = STATUS_DONE;
                  result.last   = req_end_of_stream;
                  phase_in      = PH_SKIP;
               end else if (((req_data_byte & NIBBLE_MASK) == 8'h00) || req_end_of_stream) begin
                  emit          = 1'b1;
                  result.status = STATUS_CORRUPT;
                  result.last   = 1'b1;
                  phase_in      = PH_SKIP;
               end else begin
                  len_total_in = req_data_byte[3:0];
                  off_total_in = req_data_byte[7:4];
                  count_in     = '0;
                  len_acc_in   = '0;
                  delta_acc_in = '0;
                  phase_in     = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               count_in   = count_next;
               len_acc_in = len_gathered;
               if (count_next == len_total_ff) begin
                  len_acc_in = len_final;
                  if (off_total_ff == 4'd0) begin
                     // hole run: no offset bytes, cluster position holds
                     emit          = 1'b1;
                     result.vcn    = virt_pos_ff;
                     result.lcn    = '1;
                     result.length = len_final;
                     result.hole   = 1'b1;
                     result.status = STATUS_RUN;
                     result.last   = req_end_of_stream;
                     virt_pos_in   = virt_pos_ff + len_final;
                     phase_in      = PH_HEADER;
                  end else if (req_end_of_stream) begin
                     emit          = 1'b1;
                     result.status = STATUS_CORRUPT;
                     result.last   = 1'b1;
                  end else begin
                     count_in = '0;
                     phase_in = PH_OFFSET;
                  end
               end else if (req_end_of_stream) begin
                  emit          = 1'b1;
                  result.status = STATUS_CORRUPT;
                  result.last   = 1'b1;
               end
            end
            PH_OFFSET: begin
               count_in     = count_next;
               delta_acc_in = delta_gathered;
               if (count_next == off_total_ff) begin
                  delta_acc_in    = delta_final;
                  emit            = 1'b1;
                  result.vcn      = virt_pos_ff;
                  result.lcn      = cluster_sum;
                  result.length   = len_acc_ff;
                  result.hole     = 1'b0;
                  result.status   = STATUS_RUN;
                  result.last     = req_end_of_stream;
                  prev_cluster_in = cluster_sum;
                  virt_pos_in     = virt_pos_ff + len_acc_ff;
                  phase_in        = PH_HEADER;
               end else if (req_end_of_stream) begin
                  emit          = 1'b1;
                  result.status = STATUS_CORRUPT;
                  result.last   = 1'b1;
               end
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase

         // end of stream always starts the next attribute from scratch
         if (req_end_of_stream) begin
            phase_in        = PH_HEADER;
            len_total_in    = '0;
            off_total_in    = '0;
            count_in        = '0;
            len_acc_in      = '0;
            delta_acc_in    = '0;
            prev_cluster_in = '0;
            virt_pos_in     = '0;
         end
      end
   end

   // result register with a skid register behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || out_fire) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (emit) begin
            out_valid_in = 1'b1;
            out_in       = result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (emit) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         len_total_ff    <= '0;
         off_total_ff    <= '0;
         count_ff        <= '0;
         len_acc_ff      <= '0;
         delta_acc_ff    <= '0;
         prev_cluster_ff <= '0;
         virt_pos_ff     <= '0;
         out_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         len_total_ff    <= len_total_in;
         off_total_ff    <= off_total_in;
         count_ff        <= count_in;
         len_acc_ff      <= len_acc_in;
         delta_acc_ff    <= delta_acc_in;
         prev_cluster_ff <= prev_cluster_in;
         virt_pos_ff     <= virt_pos_in;
         out_valid_ff    <= out_valid_in;
         skid_valid_ff   <= skid_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_run_vcn    = out_ff.vcn;
   assign rsp_run_lcn    = signed'(out_ff.lcn);
   assign rsp_run_length = signed'(out_ff.length);
   assign rsp_is_hole    = out_ff.hole;
   assign rsp_status     = out_ff.status;
   assign rsp_last       = out_ff.last;

   // skid entry only exists behind a full result register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while result register empty");

   // a result made while the receiver stalls lands in the skid register
   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready && req_fire && emit) |=> skid_valid_ff)
      else $error("result lost during receiver stall");

   // skipped bytes never produce a result
   a_skip_silent: assert property (@(posedge clock) disable iff (reset)
      (req_fire && phase_ff == PH_SKIP) |-> !emit)
      else $error("result produced while skipping");

   // hole runs report an all-ones cluster
   a_hole_lcn: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.hole) |-> (out_ff.lcn == {WordWidth{1'b1}}))
      else $error("hole run with a real cluster");

   // corrupt always closes the stream
   a_corrupt_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.status == STATUS_CORRUPT) |-> out_ff.last)
      else $error("corrupt result without last");

endmodule
